>>> rtl/hee_pkg.sv
// shared types, constants and the entity name rom for the html entity escaper
// depends on nothing; imported by every module of the block
package hee_pkg;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in_word;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       string_last;
    } t_out_word;

    localparam int NAME_CHARS = 6;
    localparam int NAME_W     = 8 * NAME_CHARS;
    localparam int POS_W      = 3;

    // classified word as it travels from front to back
    typedef struct packed {
        logic [7:0]        chr;
        logic              last;
        logic              is_ent;
        logic [POS_W-1:0]  last_pos;
        logic [NAME_W-1:0] name;
    } t_cmd;

    // front to queue handshake group
    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_cmd_chan;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [7:0] CH_QUOT = 8'h22;
    localparam logic [7:0] CH_AMP  = 8'h26;
    localparam logic [7:0] CH_SEMI = 8'h3B;
    localparam logic [7:0] CH_LT   = 8'h3C;
    localparam logic [7:0] CH_GT   = 8'h3E;
    localparam logic [7:0] HI_BASE = 8'd160;
    localparam int         HI_COUNT = 96;

    // names are right aligned, zero filled above the first character
    localparam logic [NAME_W-1:0] HI_NAMES [0:HI_COUNT-1] = '{
        48'("nbsp"),   48'("iexcl"),  48'("cent"),   48'("pound"),
        48'("curren"), 48'("yen"),    48'("brvbar"), 48'("sect"),
        48'("uml"),    48'("copy"),   48'("ordf"),   48'("laquo"),
        48'("not"),    48'("shy"),    48'("reg"),    48'("macr"),
        48'("deg"),    48'("plusmn"), 48'("sup2"),   48'("sup3"),
        48'("acute"),  48'("micro"),  48'("para"),   48'("middot"),
        48'("cedil"),  48'("sup1"),   48'("ordm"),   48'("raquo"),
        48'("frac14"), 48'("frac12"), 48'("frac34"), 48'("iquest"),
        48'("Agrave"), 48'("Aacute"), 48'("Acirc"),  48'("Atilde"),
        48'("Auml"),   48'("Aring"),  48'("AElig"),  48'("Ccedil"),
        48'("Egrave"), 48'("Eacute"), 48'("Ecirc"),  48'("Euml"),
        48'("Igrave"), 48'("Iacute"), 48'("Icirc"),  48'("Iuml"),
        48'("ETH"),    48'("Ntilde"), 48'("Ograve"), 48'("Oacute"),
        48'("Ocirc"),  48'("Otilde"), 48'("Ouml"),   48'("times"),
        48'("Oslash"), 48'("Ugrave"), 48'("Uacute"), 48'("Ucirc"),
        48'("Uuml"),   48'("Yacute"), 48'("THORN"),  48'("szlig"),
        48'("agrave"), 48'("aacute"), 48'("acirc"),  48'("atilde"),
        48'("auml"),   48'("aring"),  48'("aelig"),  48'("ccedil"),
        48'("egrave"), 48'("eacute"), 48'("ecirc"),  48'("euml"),
        48'("igrave"), 48'("iacute"), 48'("icirc"),  48'("iuml"),
        48'("eth"),    48'("ntilde"), 48'("ograve"), 48'("oacute"),
        48'("ocirc"),  48'("otilde"), 48'("ouml"),   48'("divide"),
        48'("oslash"), 48'("ugrave"), 48'("uacute"), 48'("ucirc"),
        48'("uuml"),   48'("yacute"), 48'("thorn"),  48'("yuml")
    };

    // entity name for a byte, all zero when the byte passes through
    function automatic logic [NAME_W-1:0] ent_name(input logic [7:0] b);
        logic [NAME_W-1:0] nm;
        logic [6:0]        idx;
        nm  = '0;
        idx = 7'(b - HI_BASE);
        unique case (b)
            CH_AMP:  nm = NAME_W'("amp");
            CH_LT:   nm = NAME_W'("lt");
            CH_GT:   nm = NAME_W'("gt");
            CH_QUOT: nm = NAME_W'("quot");
            default: begin
                if (b >= HI_BASE) begin
                    nm = HI_NAMES[idx];
                end
            end
        endcase
        return nm;
    endfunction

    // number of characters in a right aligned name
    function automatic logic [POS_W-1:0] name_len(input logic [NAME_W-1:0] nm);
        logic [POS_W-1:0] n;
        n = '0;
        for (int k = 0; k < NAME_CHARS; k++) begin
            if (nm[8*k +: 8] != 8'h00) begin
                n = n + 1'b1;
            end
        end
        return n;
    endfunction

endpackage

>>> rtl/html_entity_escaper_unit.sv
// html entity escaper: input words pass the front register, queue and output register
// throughput: one input word per cycle into the front unless the queue is full; the
// back emits a character per cycle unless stalled; an entity is 4 to 8 characters
// the 4-entry command queue lets the front keep taking words while an entity drains
// reset (synchronous, active low) empties the front register, queue and output register
// depends on hee_pkg, hee_front, hee_queue, hee_back
module html_entity_escaper_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input channel
    input  logic               i_in_valid,
    input  hee_pkg::t_in_word  i_in_word,
    output logic               o_in_stall,
    // output channel
    output logic               o_out_valid,
    output hee_pkg::t_out_word o_out_word,
    input  logic               i_out_stall
);
    import hee_pkg::*;

    // front to queue word and its backpressure
    t_cmd_chan f_chan;
    logic      q_full;

    // queue head seen by the back end
    logic      q_valid;
    t_cmd      q_head;
    logic      q_pop;

    // front: rom lookup of the entity name and run length, one register stage
    hee_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_in_valid),
        .i_word   (i_in_word),
        .o_stall  (o_in_stall),
        .o_chan   (f_chan),
        .i_q_full (q_full)
    );

    // decoupling queue, lets the front run on while the back expands an entity
    hee_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_chan  (f_chan),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_head  (q_head),
        .i_pop   (q_pop)
    );

    // back: character sequencer feeding the output register
    hee_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_head    (q_head),
        .o_pop     (q_pop),
        .o_valid   (o_out_valid),
        .o_word    (o_out_word),
        .i_stall   (i_out_stall)
    );

endmodule

>>> rtl/hee_front.sv
// front stage: accepts input words, looks up the entity name, registers a command
// depends on hee_pkg
module hee_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  hee_pkg::t_in_word i_word,
    output logic              o_stall,
    output hee_pkg::t_cmd_chan o_chan,
    input  logic              i_q_full
);
    import hee_pkg::*;

    logic              r_valid;
    t_cmd              r_cmd;
    t_cmd              n_cmd;
    logic [NAME_W-1:0] nm;
    logic [POS_W-1:0]  len;
    logic              take;

    always_comb begin
        nm             = ent_name(i_word.in_byte);
        len            = name_len(nm);
        n_cmd.chr      = i_word.in_byte;
        n_cmd.last     = i_word.in_last;
        n_cmd.is_ent   = (len != '0);
        n_cmd.last_pos = (len != '0) ? POS_W'(len + 1'b1) : '0;
        n_cmd.name     = nm;
    end

    // the register frees up when the queue takes its word
    assign o_stall = r_valid && i_q_full;
    assign take    = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= 1'b1;
        end else if (!i_q_full) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_cmd <= n_cmd;
        end
    end

    assign o_chan.valid = r_valid;
    assign o_chan.cmd   = r_cmd;

endmodule

>>> rtl/hee_queue.sv
// short command queue between front and back
// depends on hee_pkg
module hee_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  hee_pkg::t_cmd_chan i_chan,
    output logic               o_full,
    output logic               o_valid,
    output hee_pkg::t_cmd      o_head,
    input  logic               i_pop
);
    import hee_pkg::*;

    t_cmd              r_mem [0:QDEPTH-1];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QCNT_W-1:0] r_cnt;
    logic              push;
    logic              pop;

    assign o_full  = (r_cnt == QCNT_W'(QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_head  = r_mem[r_rd];
    assign push    = i_chan.valid && !o_full;
    assign pop     = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= r_rd + 1'b1;
            end
            unique case ({push, pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_chan.cmd;
        end
    end

endmodule

>>> rtl/hee_back.sv
// back end: walks each command one character per cycle, unless the output stalls, into the output register
// depends on hee_pkg
module hee_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  hee_pkg::t_cmd      i_head,
    output logic               o_pop,
    output logic               o_valid,
    output hee_pkg::t_out_word o_word,
    input  logic               i_stall
);
    import hee_pkg::*;

    logic             r_ovalid;
    t_out_word        r_out;
    logic [POS_W-1:0] r_pos;
    logic [POS_W-1:0] sh;
    logic [7:0]       chr;
    logic             at_end;
    logic             load;

    assign at_end = (r_pos == i_head.last_pos);
    assign load   = i_q_valid && (!r_ovalid || !i_stall);
    assign o_pop  = load && at_end;
    assign sh     = POS_W'(i_head.last_pos - 1'b1 - r_pos);

    always_comb begin
        priority if (r_pos == '0) begin
            chr = i_head.is_ent ? CH_AMP : i_head.chr;
        end else if (at_end) begin
            chr = CH_SEMI;
        end else begin
            chr = i_head.name[{sh, 3'b000} +: 8];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
            r_pos    <= '0;
        end else begin
            if (load) begin
                r_ovalid <= 1'b1;
                r_pos    <= at_end ? '0 : POS_W'(r_pos + 1'b1);
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out.out_byte    <= chr;
            r_out.run_last    <= at_end;
            r_out.string_last <= at_end && i_head.last;
        end
    end

    assign o_valid = r_ovalid;
    assign o_word  = r_out;

    a_strlast_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> (!r_out.string_last || r_out.run_last))
        else $error("string_last without run_last");

    a_pos_wraps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_pos == '0))
        else $error("position not cleared after pop");

    a_pos_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && !at_end) |=> (r_pos == POS_W'($past(r_pos) + 1'b1)))
        else $error("position did not advance");

    a_pass_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_q_valid && !i_head.is_ent) |-> (i_head.last_pos == '0))
        else $error("pass-through word with several characters");

endmodule
